### rtl/spe_pkg.sv
package spe_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 16;
    localparam int ELEM_W     = 12;
    localparam int VAL_W      = 16;

    // long division k*L/d, quotient known to stay below 2^28
    localparam int NUM_W      = 40;
    localparam int QUO_W      = 28;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;

    // series units
    localparam int EXP_TERMS  = 14;
    localparam int TRIG_TERMS = 10;
    localparam int TERM_W     = 32;
    localparam int MUL_W      = 32;
    localparam int SUM_W      = 34;
    localparam int RECIP_W    = 33;
    localparam int DIVR_W     = 9;

    localparam logic [27:0] LOG2_1E4_Q24 = 28'd222930821;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [34:0] TWO_PI_Q32   = 35'd26986075409;
    localparam logic [34:0] HALF_PI_Q32  = 35'd6746518852;
    localparam logic [34:0] PI_Q32       = 35'd13493037704;
    localparam logic [34:0] PI3_2_Q32    = 35'd20239556556;
    localparam logic [TERM_W-1:0] ONE_Q30 = 32'h4000_0000;

    // reciprocal for the reduction modulo 2*pi
    localparam int RED_SHIFT   = 49;
    localparam int RED_RECIP_W = 15;
    localparam logic [RED_RECIP_W-1:0] TWO_PI_RECIP =
        RED_RECIP_W'((64'd1 << RED_SHIFT) / 64'd26986075409);

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             odd;
        logic             oor;
        logic [3:0]       n;
        logic [1:0]       quad;
        logic [MUL_W-1:0] mul;
    } side_t;

endpackage

### rtl/spe_div.sv
module spe_div import spe_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  side_t            in_side,
    input  logic [NUM_W-1:0] num,
    input  logic [DIM_W-1:0] den,
    output logic             out_valid,
    output side_t            out_side,
    output logic [QUO_W-1:0] quo
);

    wire logic [DIM_W-1:0] rem_w  [DIV_STAGES+1];
    wire logic [QUO_W-1:0] qr_w   [DIV_STAGES+1];
    wire logic             v_w    [DIV_STAGES+1];
    wire side_t            side_w [DIV_STAGES+1];

    function automatic logic [DIM_W+QUO_W-1:0] div_step(
        input logic [DIM_W-1:0] rem,
        input logic [QUO_W-1:0] qr,
        input logic [DIM_W-1:0] d
    );
        logic [DIM_W:0]   r2;
        logic [DIM_W-1:0] rem_o;
        logic             qbit;
        r2 = {rem, qr[QUO_W-1]};
        if (r2 >= {1'b0, d}) begin
            rem_o = DIM_W'(r2 - {1'b0, d});
            qbit  = 1'b1;
        end else begin
            rem_o = r2[DIM_W-1:0];
            qbit  = 1'b0;
        end
        return {rem_o, qr[QUO_W-2:0], qbit};
    endfunction

    // top quotient bits are zero since k < d, so the high dividend bits start as remainder
    assign rem_w[0]  = DIM_W'(num[NUM_W-1:QUO_W]);
    assign qr_w[0]   = num[QUO_W-1:0];
    assign v_w[0]    = in_valid;
    assign side_w[0] = in_side;

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic [DIM_W-1:0] rem_reg;
        logic [QUO_W-1:0] qr_reg;
        logic             v_reg;
        side_t            side_reg;
        logic [DIM_W+QUO_W-1:0] step_next [DIV_STEP+1];

        always_comb begin
            step_next[0] = {rem_w[i], qr_w[i]};
            for (int b = 0; b < DIV_STEP; b++) begin
                step_next[b+1] = div_step(step_next[b][DIM_W+QUO_W-1:QUO_W],
                                          step_next[b][QUO_W-1:0], den);
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg  <= step_next[DIV_STEP][DIM_W+QUO_W-1:QUO_W];
                qr_reg   <= step_next[DIV_STEP][QUO_W-1:0];
                side_reg <= side_w[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (ce) begin
                v_reg <= v_w[i];
            end
        end

        assign rem_w[i+1]  = rem_reg;
        assign qr_w[i+1]   = qr_reg;
        assign v_w[i+1]    = v_reg;
        assign side_w[i+1] = side_reg;
    end

    assign out_valid = v_w[DIV_STAGES];
    assign out_side  = side_w[DIV_STAGES];
    assign quo       = qr_w[DIV_STAGES];

endmodule

### rtl/spe_term.sv
module spe_term import spe_pkg::*; (
    input  logic                     aclk,
    input  logic                     ce,
    input  logic [MUL_W-1:0]         mul,
    input  logic [TERM_W-1:0]        term_in,
    input  logic signed [SUM_W-1:0]  sum_in,
    input  logic [DIVR_W-1:0]        divisor,
    input  logic [RECIP_W-1:0]       recip,
    input  logic                     negate,
    output logic [TERM_W-1:0]        term_out,
    output logic signed [SUM_W-1:0]  sum_out
);

    localparam int PW = TERM_W + MUL_W;
    localparam int MW = TERM_W + RECIP_W;
    localparam int BW = TERM_W + DIVR_W;

    logic [PW-1:0]            prod_reg;
    logic signed [SUM_W-1:0]  sum_a_reg;
    logic [TERM_W-1:0]        p_reg;
    logic [MW-1:0]            m_reg;
    logic signed [SUM_W-1:0]  sum_b_reg;
    logic [TERM_W-1:0]        term_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic [TERM_W-1:0]        p;
    logic [TERM_W-1:0]        q0;
    logic [BW-1:0]            back;
    logic [BW-1:0]            rem;
    logic [TERM_W-1:0]        q_next;
    logic signed [SUM_W-1:0]  sum_next;

    assign p = prod_reg[TERM_W+29:30];

    // reciprocal estimate is exact or one short, fixed by the remainder check
    always_comb begin
        q0     = m_reg[2*TERM_W-1:TERM_W];
        back   = BW'(q0) * BW'(divisor);
        rem    = BW'(p_reg) - back;
        q_next = (rem >= BW'(divisor)) ? q0 + TERM_W'(1) : q0;
        if (negate) begin
            sum_next = sum_b_reg - $signed(SUM_W'(q_next));
        end else begin
            sum_next = sum_b_reg + $signed(SUM_W'(q_next));
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg  <= PW'(term_in) * PW'(mul);
            sum_a_reg <= sum_in;
            p_reg     <= p;
            m_reg     <= MW'(p) * MW'(recip);
            sum_b_reg <= sum_a_reg;
            term_reg  <= q_next;
            sum_reg   <= sum_next;
        end
    end

    assign term_out = term_reg;
    assign sum_out  = sum_reg;

endmodule

### rtl/sinusoidal_position_encoder.sv
// sinusoidal position encoder: one encoding element per item
// s_tdata carries position [15:0] and element_index [27:16]; the reply on
// m_tdata is value, signed Q1.15, with m_tuser set when element_index is not
// below the embedding size (value is then zero)
// cfg_we/cfg_wdata write the embedding size, only while no item is in flight
// (the user must keep to this; the block does not enforce it); sizes above 4096 act as 4096
// throughput is one item per clock while m_tready does not stall; each item
// passes through the pipeline: 14 stages of the radix-4 divider for
// k*log2(1e4)/d, 42 stages of the exp series (three per term), 30 stages of
// the sin/cos series and the stages around them for the frequency, modulo
// 2*pi reduction, quadrant and rounding
// a stall on m_tready freezes the whole pipeline in place and drops s_tready
// in the same cycle, so nothing is lost or repeated
// reset (aresetn low, synchronous) empties the pipeline and sets the
// embedding size to 512
module sinusoidal_position_encoder import spe_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [DIM_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // position [15:0], element_index [27:16]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // value [15:0]
    output logic             m_tuser    // index_out_of_range [0]
);

    logic ce;
    logic [DIM_W-1:0] dim_reg;
    logic [DIM_W-1:0] dim_eff;

    logic m_tvalid_reg;
    logic [VAL_W-1:0] m_value_reg;
    logic m_oor_reg;

    assign ce       = ~m_tvalid_reg | m_tready;
    assign s_tready = ce;
    assign dim_eff  = (dim_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_W'(512);
        end else if (cfg_we) begin
            dim_reg <= cfg_wdata;
        end
    end

    // stage 1: capture, range check
    logic [POS_W-1:0]  in_pos;
    logic [ELEM_W-1:0] in_elem;
    side_t             side1_next;
    logic              v1_reg;
    side_t             side1_reg;
    logic [ELEM_W-1:0] k1_reg;

    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_elem = s_tdata[POS_W+ELEM_W-1:POS_W];

    always_comb begin
        side1_next      = '0;
        side1_next.pos  = in_pos;
        side1_next.odd  = in_elem[0];
        side1_next.oor  = ({1'b0, in_elem} >= dim_eff);
    end

    // stage 2: numerator k * log2(1e4)
    logic              v2_reg;
    side_t             side2_reg;
    logic [NUM_W-1:0]  num2_reg;

    // divider
    logic              div_v;
    side_t             div_side;
    logic [QUO_W-1:0]  div_quo;

    spe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v2_reg),
        .in_side   (side2_reg),
        .num       (num2_reg),
        .den       (dim_eff),
        .out_valid (div_v),
        .out_side  (div_side),
        .quo       (div_quo)
    );

    // stage 3: integer part of the exponent and x = frac * ln2
    logic              v3_reg;
    side_t             side3_reg;
    logic [53:0]       xprod3_reg;
    side_t             side3_next;

    always_comb begin
        side3_next   = div_side;
        side3_next.n = div_quo[QUO_W-1:24];
    end

    // exp(-x) series
    wire logic                    exp_v    [EXP_TERMS+1];
    wire side_t                   exp_side [EXP_TERMS+1];
    wire logic [TERM_W-1:0]       exp_term [EXP_TERMS+1];
    wire logic signed [SUM_W-1:0] exp_sum  [EXP_TERMS+1];
    side_t                        exp_side0;

    always_comb begin
        exp_side0     = side3_reg;
        exp_side0.mul = MUL_W'(xprod3_reg[53:24]);
    end

    assign exp_v[0]    = v3_reg;
    assign exp_side[0] = exp_side0;
    assign exp_term[0] = ONE_Q30;
    assign exp_sum[0]  = $signed(SUM_W'(ONE_Q30));

    for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
        localparam int ORDER = j + 1;
        localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / 64'(ORDER));
        logic [2:0] v_reg;
        side_t      side_reg [3];

        spe_term u_term (
            .aclk     (aclk),
            .ce       (ce),
            .mul      (exp_side[j].mul),
            .term_in  (exp_term[j]),
            .sum_in   (exp_sum[j]),
            .divisor  (DIVR_W'(ORDER)),
            .recip    (RECIP),
            .negate   ((ORDER % 2) == 1),
            .term_out (exp_term[j+1]),
            .sum_out  (exp_sum[j+1])
        );

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[0] <= exp_side[j];
                side_reg[1] <= side_reg[0];
                side_reg[2] <= side_reg[1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= '0;
            end else if (ce) begin
                v_reg <= {v_reg[1:0], exp_v[j]};
            end
        end

        assign exp_v[j+1]    = v_reg[2];
        assign exp_side[j+1] = side_reg[2];
    end

    // stage 4: frequency f = (g << 2) >> n
    logic        v4_reg;
    side_t       side4_reg;
    logic [32:0] f4_reg;

    // stage 5: position * f
    logic        v5_reg;
    side_t       side5_reg;
    logic [48:0] prod5_reg;

    // stage 6: reciprocal estimate of the 2*pi multiple
    logic        v6_reg;
    side_t       side6_reg;
    logic [48:0] prod6_reg;
    logic [63:0] m6_reg;

    // stage 7: multiple times 2*pi
    logic        v7_reg;
    side_t       side7_reg;
    logic [48:0] prod7_reg;
    logic [49:0] qc7_reg;

    // stage 8: angle modulo 2*pi
    logic        v8_reg;
    side_t       side8_reg;
    logic [34:0] a8_reg;
    logic [48:0] rem8;
    logic [34:0] a8_next;

    always_comb begin
        rem8 = prod7_reg - qc7_reg[48:0];
        if (rem8 >= 49'(TWO_PI_Q32)) begin
            a8_next = 35'(rem8 - 49'(TWO_PI_Q32));
        end else begin
            a8_next = rem8[34:0];
        end
    end

    // stage 9: quadrant and reduced angle
    logic        v9_reg;
    side_t       side9_reg;
    logic [30:0] y9_reg;
    logic [1:0]  quad9_next;
    logic [34:0] u9;
    side_t       side9_next;

    always_comb begin
        if (a8_reg >= PI3_2_Q32) begin
            quad9_next = 2'd3;
            u9         = a8_reg - PI3_2_Q32;
        end else if (a8_reg >= PI_Q32) begin
            quad9_next = 2'd2;
            u9         = a8_reg - PI_Q32;
        end else if (a8_reg >= HALF_PI_Q32) begin
            quad9_next = 2'd1;
            u9         = a8_reg - HALF_PI_Q32;
        end else begin
            quad9_next = 2'd0;
            u9         = a8_reg;
        end
        side9_next      = side8_reg;
        side9_next.quad = quad9_next;
    end

    // stage 10: y squared
    logic        v10_reg;
    side_t       side10_reg;
    logic [30:0] y10_reg;
    logic [61:0] yy10;
    side_t       side10_next;

    always_comb begin
        yy10            = 62'(y9_reg) * 62'(y9_reg);
        side10_next     = side9_reg;
        side10_next.mul = yy10[61:30];
    end

    // sin and cos series side by side
    wire logic                    trig_v    [TRIG_TERMS+1];
    wire side_t                   trig_side [TRIG_TERMS+1];
    wire logic [TERM_W-1:0]       sin_term  [TRIG_TERMS+1];
    wire logic signed [SUM_W-1:0] sin_sum   [TRIG_TERMS+1];
    wire logic [TERM_W-1:0]       cos_term  [TRIG_TERMS+1];
    wire logic signed [SUM_W-1:0] cos_sum   [TRIG_TERMS+1];

    assign trig_v[0]    = v10_reg;
    assign trig_side[0] = side10_reg;
    assign sin_term[0]  = TERM_W'(y10_reg);
    assign sin_sum[0]   = $signed(SUM_W'(y10_reg));
    assign cos_term[0]  = ONE_Q30;
    assign cos_sum[0]   = $signed(SUM_W'(ONE_Q30));

    for (genvar j = 0; j < TRIG_TERMS; j++) begin : g_trig
        localparam int SIN_DIV = (2 * j + 3) * (2 * j + 2);
        localparam int COS_DIV = (2 * j + 2) * (2 * j + 1);
        localparam logic [RECIP_W-1:0] SIN_RECIP =
            RECIP_W'((64'd1 << 32) / 64'(SIN_DIV));
        localparam logic [RECIP_W-1:0] COS_RECIP =
            RECIP_W'((64'd1 << 32) / 64'(COS_DIV));
        logic [2:0] v_reg;
        side_t      side_reg [3];

        spe_term u_sin (
            .aclk     (aclk),
            .ce       (ce),
            .mul      (trig_side[j].mul),
            .term_in  (sin_term[j]),
            .sum_in   (sin_sum[j]),
            .divisor  (DIVR_W'(SIN_DIV)),
            .recip    (SIN_RECIP),
            .negate   ((j % 2) == 0),
            .term_out (sin_term[j+1]),
            .sum_out  (sin_sum[j+1])
        );

        spe_term u_cos (
            .aclk     (aclk),
            .ce       (ce),
            .mul      (trig_side[j].mul),
            .term_in  (cos_term[j]),
            .sum_in   (cos_sum[j]),
            .divisor  (DIVR_W'(COS_DIV)),
            .recip    (COS_RECIP),
            .negate   ((j % 2) == 0),
            .term_out (cos_term[j+1]),
            .sum_out  (cos_sum[j+1])
        );

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[0] <= trig_side[j];
                side_reg[1] <= side_reg[0];
                side_reg[2] <= side_reg[1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= '0;
            end else if (ce) begin
                v_reg <= {v_reg[1:0], trig_v[j]};
            end
        end

        assign trig_v[j+1]    = v_reg[2];
        assign trig_side[j+1] = side_reg[2];
    end

    // stage 11: quadrant select, magnitude, rounding to Q15
    logic                    v11_reg;
    logic                    oor11_reg;
    logic                    neg11_reg;
    logic [20:0]             rnd11_reg;
    logic signed [SUM_W-1:0] base11;
    logic                    flip11;
    logic signed [SUM_W:0]   val11;
    logic [SUM_W:0]          mag11;
    logic [SUM_W+1:0]        rsum11;
    side_t                   tside;

    assign tside = trig_side[TRIG_TERMS];

    always_comb begin
        // even element: s, c, -s, -c; odd element: c, -s, -c, s
        case (tside.quad)
            2'd0: begin
                base11 = tside.odd ? cos_sum[TRIG_TERMS] : sin_sum[TRIG_TERMS];
                flip11 = 1'b0;
            end
            2'd1: begin
                base11 = tside.odd ? sin_sum[TRIG_TERMS] : cos_sum[TRIG_TERMS];
                flip11 = tside.odd;
            end
            2'd2: begin
                base11 = tside.odd ? cos_sum[TRIG_TERMS] : sin_sum[TRIG_TERMS];
                flip11 = 1'b1;
            end
            default: begin
                base11 = tside.odd ? sin_sum[TRIG_TERMS] : cos_sum[TRIG_TERMS];
                flip11 = ~tside.odd;
            end
        endcase
        val11  = flip11 ? -(SUM_W+1)'(base11) : (SUM_W+1)'(base11);
        mag11  = val11[SUM_W] ? (SUM_W+1)'(-val11) : (SUM_W+1)'(val11);
        rsum11 = (SUM_W+2)'(mag11) + (SUM_W+2)'(1 << 14);
    end

    // output stage: saturate
    logic [VAL_W-1:0] value_next;

    always_comb begin
        if (oor11_reg) begin
            value_next = '0;
        end else if (neg11_reg) begin
            if (rnd11_reg > 21'd32768) begin
                value_next = 16'h8000;
            end else begin
                value_next = VAL_W'(-rnd11_reg);
            end
        end else if (rnd11_reg > 21'd32767) begin
            value_next = 16'h7FFF;
        end else begin
            value_next = rnd11_reg[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side1_reg   <= side1_next;
            k1_reg      <= {in_elem[ELEM_W-1:1], 1'b0};
            side2_reg   <= side1_reg;
            num2_reg    <= NUM_W'(k1_reg) * NUM_W'(LOG2_1E4_Q24);
            side3_reg   <= side3_next;
            xprod3_reg  <= 54'(div_quo[23:0]) * 54'(LN2_Q30);
            side4_reg   <= exp_side[EXP_TERMS];
            f4_reg      <= 33'({exp_sum[EXP_TERMS][30:0], 2'b00}) >> exp_side[EXP_TERMS].n;
            side5_reg   <= side4_reg;
            prod5_reg   <= 49'(side4_reg.pos) * 49'(f4_reg);
            side6_reg   <= side5_reg;
            prod6_reg   <= prod5_reg;
            m6_reg      <= 64'(prod5_reg) * 64'(TWO_PI_RECIP);
            side7_reg   <= side6_reg;
            prod7_reg   <= prod6_reg;
            qc7_reg     <= 50'(m6_reg[63:RED_SHIFT]) * 50'(TWO_PI_Q32);
            side8_reg   <= side7_reg;
            a8_reg      <= a8_next;
            side9_reg   <= side9_next;
            y9_reg      <= u9[32:2];
            side10_reg  <= side10_next;
            y10_reg     <= y9_reg;
            oor11_reg   <= tside.oor;
            neg11_reg   <= val11[SUM_W];
            rnd11_reg   <= rsum11[35:15];
            m_value_reg <= value_next;
            m_oor_reg   <= oor11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            v9_reg       <= 1'b0;
            v10_reg      <= 1'b0;
            v11_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= div_v;
            v4_reg       <= exp_v[EXP_TERMS];
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            v7_reg       <= v6_reg;
            v8_reg       <= v7_reg;
            v9_reg       <= v8_reg;
            v10_reg      <= v9_reg;
            v11_reg      <= trig_v[TRIG_TERMS];
            m_tvalid_reg <= v11_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_oor_reg;

endmodule

### test/sinusoidal_position_encoder_test.sv
module sinusoidal_position_encoder_test;
    import spe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_CYCLES   = 98;
    localparam int STALL_LIMIT   = 2000;
    localparam longint unsigned L_Q24     = 64'd222930821;
    localparam longint unsigned LN2_Q30_C = 64'd744261118;
    localparam longint unsigned TWO_PI    = 64'd26986075409;
    localparam longint unsigned HALF_PI   = 64'd6746518852;
    localparam longint unsigned ONE_Q30_C = 64'd1073741824;

    typedef struct {
        logic [15:0] value;
        logic        oor;
    } enc_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [DIM_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [31:0]      s_tdata;   // position [15:0], element_index [27:16]
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;   // value [15:0]
    logic             m_tuser;   // index_out_of_range [0]

    logic [DIM_W-1:0] dim_shadow;
    enc_t             expected_q[$];
    int               mismatches;
    int               idle_cycles;
    bit               quiet;

    sinusoidal_position_encoder dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint exp_neg(longint unsigned x);
        longint unsigned term;
        longint sum;
        term = ONE_Q30_C;
        sum = longint'(ONE_Q30_C);
        for (int o = 1; o <= 14; o++) begin
            term = ((term * x) >> 30) / o;
            if (o % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return sum;
    endfunction

    function automatic longint sincos(longint unsigned y, bit odd);
        longint unsigned y2, term;
        longint sum;
        bit neg;
        y2 = (y * y) >> 30;
        term = odd ? y : ONE_Q30_C;
        sum = longint'(term);
        neg = 1;
        for (longint unsigned o = odd ? 3 : 2; o <= 21; o += 2) begin
            term = ((term * y2) >> 30) / (o * (o - 1));
            if (neg) sum -= longint'(term);
            else sum += longint'(term);
            neg = !neg;
        end
        return sum;
    endfunction

    function automatic enc_t encode(logic [15:0] pos, logic [11:0] elem);
        longint unsigned d, k, t, n, r, x, f, a, q, y, mag;
        longint g, s, c, v, res;
        enc_t e;
        d = (dim_shadow > MAX_DIM) ? MAX_DIM : dim_shadow;
        if (elem >= d) begin
            e.value = '0;
            e.oor = 1;
            return e;
        end
        k = elem & 12'hffe;
        t = (k * L_Q24) / d;
        n = t >> 24;
        r = t & 64'hffffff;
        x = (r * LN2_Q30_C) >> 24;
        g = exp_neg(x);
        f = (longint'(g) << 2) >> n;
        a = (longint'(pos) * f) % TWO_PI;
        q = a / HALF_PI;
        if (q > 3) q = 3;
        y = (a - q * HALF_PI) >> 2;
        s = sincos(y, 1);
        c = sincos(y, 0);
        if (!elem[0]) v = (q == 0) ? s : (q == 1) ? c : (q == 2) ? -s : -c;
        else          v = (q == 0) ? c : (q == 1) ? -s : (q == 2) ? -c : s;
        mag = (v < 0) ? -v : v;
        mag = (mag + (1 << 14)) >> 15;
        if (mag > 32768) mag = 32768;
        res = longint'(mag);
        if (v < 0) res = -res;
        else if (res > 32767) res = 32767;
        e.value = res[15:0];
        e.oor = 0;
        return e;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // result checker and receiver-side stall generator
    initial begin
        enc_t want;
        int   burst;
        burst = 0;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected item", m_tdata, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.value) report("value", m_tdata, want.value);
                    if (m_tuser !== want.oor) report("range flag", m_tuser, want.oor);
                end
            end
            @(negedge aclk);
            if (burst > 0) begin
                burst--;
                m_tready <= 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 6) - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // watchdog: cycles without any accepted item
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT && (expected_q.size() != 0 || s_tvalid)) begin
                $display("sinusoidal_position_encoder_test NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(logic [15:0] pos, logic [11:0] elem);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, elem, pos};
        expected_q.push_back(encode(pos, elem));
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (PIPE_CYCLES + 4) @(negedge aclk);
    endtask

    task automatic write_dim(logic [DIM_W-1:0] dim);
        drain();
        cfg_we <= 1;
        cfg_wdata <= dim;
        @(negedge aclk);
        cfg_we <= 0;
        dim_shadow = dim;
    endtask

    task automatic test_reset_dim;
        send_item(16'd0, 12'd0);
        send_item(16'd0, 12'd1);
        send_item(16'd1, 12'd0);
        send_item(16'hffff, 12'd511);
        send_item(16'hffff, 12'd512);
        send_item(16'd100, 12'hfff);
    endtask

    task automatic test_extremes;
        write_dim(13'd4096);
        send_item(16'hffff, 12'hfff);
        send_item(16'hffff, 12'hffe);
        send_item(16'h5555, 12'h555);
        send_item(16'haaaa, 12'haaa);
        // oversized dims clamp to the maximum
        write_dim(13'h1fff);
        send_item(16'd12345, 12'hfff);
        send_item(16'd3, 12'd2);
        write_dim(13'd0);
        send_item(16'd7, 12'd0);
        write_dim(13'd1);
        send_item(16'd7, 12'd0);
        send_item(16'd7, 12'd1);
        write_dim(13'd2);
        send_item(16'd2, 12'd0);
        send_item(16'd2, 12'd1);
        send_item(16'd2, 12'd2);
    endtask

    task automatic test_random;
        logic [DIM_W-1:0] dims [6];
        logic [11:0] elem;
        dims = '{13'd512, 13'd64, 13'd4096, 13'd7, 13'd1000, 13'h1fff};
        foreach (dims[i]) begin
            write_dim(dims[i]);
            if (i == 5) quiet = 1;
            for (int j = 0; j < 125; j++) begin
                elem = $urandom_range(0, 7) == 0 ? 12'($urandom)
                     : 12'($urandom_range(0, (dims[i] > 4096 ? 4096 : dims[i]) - 1));
                send_item(16'($urandom), elem);
            end
        end
    endtask

    initial begin
        mismatches = 0;
        quiet = 0;
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        dim_shadow = 13'd512;
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_reset_dim();
        test_extremes();
        test_random();
        drain();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("sinusoidal_position_encoder_test OK");
        else
            $display("sinusoidal_position_encoder_test NOT OK");
        $finish;
    end
endmodule
